>>> sv/random_page_replacement_top_assert.svh
// Assertion macros shared by the checker of the page replacement block.
// Depends on nothing; included by the checker file.
`ifndef RANDOM_PAGE_REPLACEMENT_TOP_ASSERT_SVH
`define RANDOM_PAGE_REPLACEMENT_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define RPR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rpr assertion failed");

// Next-cycle implication, disabled while reset is low.
`define RPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rpr assertion failed");

`endif

>>> sv/rpr_pkg.sv
// Shared types, sizes and helper functions of the page replacement block.
// Depends on nothing; used by every module of the block.
`default_nettype none

package rpr_pkg;

    localparam int PROCESS_COUNT     = 4;
    localparam int PAGES_PER_PROCESS = 128;
    localparam int FRAME_COUNT       = 32;

    localparam int PROC_W     = 2;
    localparam int PAGE_W     = 7;
    localparam int FRM_W      = 5;
    localparam int IDX_W      = PROC_W + PAGE_W;
    localparam int TABLE_SIZE = PROCESS_COUNT * PAGES_PER_PROCESS;
    localparam int FILL_W     = $clog2(FRAME_COUNT + 1);
    localparam int CNT_W      = 32;

    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 104;
    localparam int OUT_TUSER_W = 2;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [FRM_W-1:0]  t_frame;
    typedef logic [FILL_W-1:0] t_fill;
    typedef logic [CNT_W-1:0]  t_count;

    localparam t_count COUNT_MAX = '1;

    typedef struct packed {
        logic   is_write;
        t_idx   idx;
        t_frame victim;
    } t_req;

    typedef struct packed {
        t_frame frame;
        logic   valid;
        logic   dirty;
    } t_pte;

    typedef struct packed {
        logic clearing;
    } t_back_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_READ,
        ST_LOOK,
        ST_EXEC,
        ST_EVICT
    } t_state;

    function automatic t_count sat_inc(input t_count v);
        sat_inc = (v == COUNT_MAX) ? v : v + t_count'(1);
    endfunction

endpackage

`default_nettype wire

>>> sv/rpr_front.sv
// Front end: accepts references, decodes them into requests and queues them.
// Depends on rpr_pkg; feeds rpr_back through a two-entry queue.
`default_nettype none

module rpr_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire logic [rpr_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    input  wire logic [rpr_pkg::IN_TUSER_W-1:0]   i_s_axis_tuser,
    input  wire rpr_pkg::t_back_status            i_status,
    output logic                                  o_req_valid,
    output rpr_pkg::t_req                         o_req,
    input  wire logic                             i_req_ready
);

    rpr_pkg::t_req r_q [0:1];
    logic          r_wptr;
    logic          r_rptr;
    logic [1:0]    r_cnt;

    rpr_pkg::t_req req_in;
    logic          push;
    logic          pop;

    always_comb begin
        req_in.is_write = (i_s_axis_tuser[0] == rpr_pkg::OP_WRITE);
        req_in.idx      = {i_s_axis_tdata[1:0], i_s_axis_tdata[8:2]};
        req_in.victim   = i_s_axis_tdata[13:9];
    end

    assign o_s_axis_tready = (r_cnt != 2'd2) && !i_status.clearing;
    assign push            = i_s_axis_tvalid && o_s_axis_tready;
    assign o_req_valid     = (r_cnt != 2'd0);
    assign pop             = o_req_valid && i_req_ready;
    assign o_req           = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= req_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

`default_nettype wire

>>> sv/rpr_back.sv
// Back end: page table and frame owner memories, replacement sequencer,
// saturating totals and the output register. Depends on rpr_pkg.
`default_nettype none

module rpr_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_req_valid,
    input  wire rpr_pkg::t_req                     i_req,
    output logic                                   o_req_ready,
    output rpr_pkg::t_back_status                  o_status,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    output logic [rpr_pkg::OUT_TDATA_W-1:0]        o_m_axis_tdata,
    output logic [rpr_pkg::OUT_TUSER_W-1:0]        o_m_axis_tuser
);

    rpr_pkg::t_pte   r_pt_mem  [0:rpr_pkg::TABLE_SIZE-1];
    rpr_pkg::t_idx   r_own_mem [0:rpr_pkg::FRAME_COUNT-1];

    rpr_pkg::t_state r_state, n_state;
    rpr_pkg::t_idx   r_clr_addr;
    rpr_pkg::t_req   r_req;
    rpr_pkg::t_pte   r_pt_rd;
    rpr_pkg::t_pte   r_cur;
    rpr_pkg::t_idx   r_own_a;
    rpr_pkg::t_idx   r_own_v;
    rpr_pkg::t_fill  r_fill;
    rpr_pkg::t_count r_fault_cnt, r_disk_cnt, r_dirty_cnt;
    rpr_pkg::t_count n_fault_cnt, n_disk_cnt, n_dirty_cnt;
    logic            r_out_valid;
    logic            r_out_fault;
    logic            r_out_wb;
    rpr_pkg::t_frame r_out_frame;

    logic            pt_we, pt_re;
    rpr_pkg::t_idx   pt_waddr, pt_raddr;
    rpr_pkg::t_pte   pt_wdata;
    logic            own_we, own_re_a, own_re_b;
    rpr_pkg::t_frame own_waddr, own_raddr_a, own_raddr_b;
    logic            out_free, out_load;
    logic            hit, free, evict, wb;
    rpr_pkg::t_frame frm;

    assign out_free = !r_out_valid || i_m_axis_tready;

    always_comb begin
        hit   = r_cur.valid && ({1'b0, r_cur.frame} < r_fill) && (r_own_a == r_req.idx);
        free  = (r_fill < rpr_pkg::t_fill'(rpr_pkg::FRAME_COUNT));
        evict = !hit && !free;
        wb    = evict && r_pt_rd.dirty;
        if (hit) begin
            frm = r_cur.frame;
        end else if (free) begin
            frm = r_fill[rpr_pkg::FRM_W-1:0];
        end else begin
            frm = r_req.victim;
        end
    end

    always_comb begin
        n_fault_cnt = rpr_pkg::sat_inc(r_fault_cnt);
        n_disk_cnt  = rpr_pkg::sat_inc(r_disk_cnt);
        n_dirty_cnt = r_dirty_cnt;
        if (wb) begin
            n_disk_cnt  = rpr_pkg::sat_inc(n_disk_cnt);
            n_dirty_cnt = rpr_pkg::sat_inc(r_dirty_cnt);
        end
    end

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        pt_we       = 1'b0;
        pt_waddr    = r_req.idx;
        pt_wdata    = '0;
        pt_re       = 1'b0;
        pt_raddr    = i_req.idx;
        own_we      = 1'b0;
        own_waddr   = frm;
        own_re_a    = 1'b0;
        own_raddr_a = r_pt_rd.frame;
        own_re_b    = 1'b0;
        own_raddr_b = i_req.victim;
        out_load    = 1'b0;
        unique case (r_state)
            rpr_pkg::ST_CLEAR: begin
                pt_we    = 1'b1;
                pt_waddr = r_clr_addr;
                if (r_clr_addr == rpr_pkg::t_idx'(rpr_pkg::TABLE_SIZE - 1)) begin
                    n_state = rpr_pkg::ST_READ;
                end
            end
            rpr_pkg::ST_READ: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    pt_re    = 1'b1;
                    own_re_b = 1'b1;
                    n_state  = rpr_pkg::ST_LOOK;
                end
            end
            rpr_pkg::ST_LOOK: begin
                pt_re    = 1'b1;
                pt_raddr = r_own_v;
                own_re_a = 1'b1;
                n_state  = rpr_pkg::ST_EXEC;
            end
            rpr_pkg::ST_EXEC: begin
                if (out_free) begin
                    out_load = 1'b1;
                    pt_we    = 1'b1;
                    if (hit) begin
                        pt_wdata = '{frame: r_cur.frame, valid: 1'b1,
                                     dirty: r_cur.dirty || r_req.is_write};
                    end else begin
                        pt_wdata = '{frame: frm, valid: 1'b1, dirty: r_req.is_write};
                        own_we   = 1'b1;
                    end
                    n_state = evict ? rpr_pkg::ST_EVICT : rpr_pkg::ST_READ;
                end
            end
            rpr_pkg::ST_EVICT: begin
                pt_we    = 1'b1;
                pt_waddr = r_own_v;
                pt_wdata = '{frame: r_pt_rd.frame, valid: 1'b0, dirty: 1'b0};
                n_state  = rpr_pkg::ST_READ;
            end
            default: begin
                n_state = rpr_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            r_pt_mem[pt_waddr] <= pt_wdata;
        end
        if (pt_re) begin
            r_pt_rd <= r_pt_mem[pt_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (own_we) begin
            r_own_mem[own_waddr] <= r_req.idx;
        end
        if (own_re_a) begin
            r_own_a <= r_own_mem[own_raddr_a];
        end
        if (own_re_b) begin
            r_own_v <= r_own_mem[own_raddr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_ready && i_req_valid) begin
            r_req <= i_req;
        end
        if (r_state == rpr_pkg::ST_LOOK) begin
            r_cur <= r_pt_rd;
        end
        if (out_load) begin
            r_out_fault <= !hit;
            r_out_wb    <= wb;
            r_out_frame <= frm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rpr_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_fill      <= '0;
            r_fault_cnt <= '0;
            r_disk_cnt  <= '0;
            r_dirty_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == rpr_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + rpr_pkg::t_idx'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                if (!hit) begin
                    r_fault_cnt <= n_fault_cnt;
                    r_disk_cnt  <= n_disk_cnt;
                    r_dirty_cnt <= n_dirty_cnt;
                    if (free) begin
                        r_fill <= r_fill + rpr_pkg::t_fill'(1);
                    end
                end
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.clearing = (r_state == rpr_pkg::ST_CLEAR);
    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tuser    = {r_out_wb, r_out_fault};
    assign o_m_axis_tdata    = {3'b000, r_dirty_cnt, r_disk_cnt, r_fault_cnt, r_out_frame};

endmodule

`default_nettype wire

>>> sv/random_page_replacement_top.sv
// Random page replacement with dirty writeback accounting, top level.
// A reference passes through the back-end sequencer states page table read, owner read
// and table update, and then an eviction write when a frame is evicted; the result is
// loaded at the table update, before the eviction write, and the update waits while the output register is full.
// After reset all 512 page table entries are cleared; no transaction is accepted then.
// Depends on rpr_pkg, rpr_front and rpr_back.
`default_nettype none

module random_page_replacement_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // [1:0] process_id, [8:2] page_number, [13:9] random_frame, [15:14] zero
    input  wire logic [rpr_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // [0] op
    input  wire logic [rpr_pkg::IN_TUSER_W-1:0]    i_s_axis_tuser,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // [4:0] frame, [36:5] fault_total, [68:37] disk_total, [100:69] dirty_total,
    // [103:101] zero
    output logic [rpr_pkg::OUT_TDATA_W-1:0]        o_m_axis_tdata,
    // [0] fault, [1] dirty_evict
    output logic [rpr_pkg::OUT_TUSER_W-1:0]        o_m_axis_tuser
);

    logic                  req_valid;
    logic                  req_ready;
    rpr_pkg::t_req         req;
    rpr_pkg::t_back_status status;

    rpr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_status        (status),
        .o_req_valid     (req_valid),
        .o_req           (req),
        .i_req_ready     (req_ready)
    );

    rpr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (req_valid),
        .i_req           (req),
        .o_req_ready     (req_ready),
        .o_status        (status),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

`default_nettype wire

>>> sv/rpr_checker.sv
// Port-level checker of the page replacement block and its bind statement.
// Depends on rpr_pkg and random_page_replacement_top_assert.svh.
`default_nettype none
`include "random_page_replacement_top_assert.svh"

module rpr_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    input  wire logic [rpr_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    input  wire logic [rpr_pkg::OUT_TUSER_W-1:0]   o_m_axis_tuser
);

    rpr_pkg::t_count r_last_fault;
    logic            r_seen;
    logic            out_acc;
    rpr_pkg::t_count fault_total, disk_total, dirty_total;
    logic [rpr_pkg::CNT_W:0] last_plus;

    assign out_acc     = o_m_axis_tvalid && i_m_axis_tready;
    assign fault_total = o_m_axis_tdata[36:5];
    assign disk_total  = o_m_axis_tdata[68:37];
    assign dirty_total = o_m_axis_tdata[100:69];
    assign last_plus   = {1'b0, r_last_fault} + {{rpr_pkg::CNT_W{1'b0}}, 1'b1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen       <= 1'b0;
            r_last_fault <= '0;
        end else if (out_acc) begin
            r_seen       <= 1'b1;
            r_last_fault <= fault_total;
        end
    end

    `RPR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
    `RPR_ASSERT_NOW(a_evict_is_fault, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[1],
        o_m_axis_tuser[0])
    `RPR_ASSERT_NOW(a_disk_bounds, i_clk, i_rst_n, o_m_axis_tvalid,
        disk_total >= fault_total && disk_total >= dirty_total)
    `RPR_ASSERT_NOW(a_fault_step, i_clk, i_rst_n, out_acc && r_seen,
        fault_total == r_last_fault || {1'b0, fault_total} == last_plus)

endmodule

bind random_page_replacement_top rpr_checker u_rpr_checker (.*);

`default_nettype wire

>>> tb/sv/rpr_result_checker.sv
// Checker for the page replacement block: watches both stream channels, keeps its own
// page table and frame owner model, and compares every result with the prediction.
// Depends on rpr_pkg for sizes and field types.
`default_nettype none

module rpr_result_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    input  wire logic                                i_s_tready,
    // [1:0] process_id, [8:2] page_number, [13:9] random_frame, [15:14] zero
    input  wire logic [rpr_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // [0] op
    input  wire logic [rpr_pkg::IN_TUSER_W-1:0]      i_s_tuser,
    input  wire logic                                i_m_tvalid,
    input  wire logic                                i_m_tready,
    // [4:0] frame, [36:5] fault_total, [68:37] disk_total, [100:69] dirty_total
    input  wire logic [rpr_pkg::OUT_TDATA_W-1:0]     i_m_tdata,
    // [0] fault, [1] dirty_evict
    input  wire logic [rpr_pkg::OUT_TUSER_W-1:0]     i_m_tuser,
    output int                                       o_fail_count,
    output int                                       o_outstanding,
    output int                                       o_references,
    output int                                       o_faults,
    output int                                       o_evictions,
    output int                                       o_writebacks
);

    typedef struct packed {
        logic            fault;
        logic            dirty_evict;
        rpr_pkg::t_frame frame;
        rpr_pkg::t_count fault_total;
        rpr_pkg::t_count disk_total;
        rpr_pkg::t_count dirty_total;
    } t_outcome;

    rpr_pkg::t_frame frame_of    [rpr_pkg::TABLE_SIZE];
    logic            page_present[rpr_pkg::TABLE_SIZE];
    logic            page_modified[rpr_pkg::TABLE_SIZE];
    rpr_pkg::t_idx   owner_of    [rpr_pkg::FRAME_COUNT];
    logic            frame_taken [rpr_pkg::FRAME_COUNT];
    rpr_pkg::t_count fault_tally;
    rpr_pkg::t_count disk_tally;
    rpr_pkg::t_count writeback_tally;

    t_outcome awaited_results[$];
    t_outcome due;
    int       fail_count;
    int       references;
    int       faults;
    int       evictions;
    int       writebacks;

    function automatic rpr_pkg::t_count hold_at_max(input rpr_pkg::t_count v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic t_outcome resolve_reference(input logic is_write,
                                                   input rpr_pkg::t_idx idx,
                                                   input rpr_pkg::t_frame victim);
        t_outcome        r;
        rpr_pkg::t_frame frm;
        rpr_pkg::t_idx   old;
        logic            hit;
        logic            found;
        r     = '0;
        frm   = '0;
        hit   = 1'b0;
        found = 1'b0;
        if (is_write == rpr_pkg::OP_WRITE) begin
            page_modified[idx] = 1'b1;
        end
        if (page_present[idx]) begin
            frm = frame_of[idx];
            hit = frame_taken[frm] && owner_of[frm] == idx;
        end
        if (!hit) begin
            r.fault     = 1'b1;
            faults++;
            fault_tally = hold_at_max(fault_tally);
            disk_tally  = hold_at_max(disk_tally);
            for (int f = 0; f < rpr_pkg::FRAME_COUNT; f++) begin
                if (!found && !frame_taken[f]) begin
                    frm   = rpr_pkg::t_frame'(f);
                    found = 1'b1;
                end
            end
            if (!found) begin
                // Every frame is in use, so the supplied victim is evicted.
                old               = owner_of[victim];
                frm               = victim;
                page_present[old] = 1'b0;
                evictions++;
                if (page_modified[old]) begin
                    r.dirty_evict      = 1'b1;
                    page_modified[old] = 1'b0;
                    writebacks++;
                    disk_tally         = hold_at_max(disk_tally);
                    writeback_tally    = hold_at_max(writeback_tally);
                end
            end
            frame_of[idx]     = frm;
            page_present[idx] = 1'b1;
            owner_of[frm]     = idx;
            frame_taken[frm]  = 1'b1;
            if (is_write == rpr_pkg::OP_READ) begin
                page_modified[idx] = 1'b0;
            end
        end
        r.frame       = frm;
        r.fault_total = fault_tally;
        r.disk_total  = disk_tally;
        r.dirty_total = writeback_tally;
        return r;
    endfunction

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("result field %s: expected %0h, actual %0h", label, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rpr_pkg::TABLE_SIZE; i++) begin
                page_present[i]  = 1'b0;
                page_modified[i] = 1'b0;
            end
            for (int i = 0; i < rpr_pkg::FRAME_COUNT; i++) begin
                frame_taken[i] = 1'b0;
            end
            fault_tally     = '0;
            disk_tally      = '0;
            writeback_tally = '0;
            awaited_results.delete();
            fail_count = 0;
            references = 0;
            faults     = 0;
            evictions  = 0;
            writebacks = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("result transaction arrived with no reference outstanding");
                    fail_count++;
                end else begin
                    due = awaited_results.pop_front();
                    check_field("fault", 32'(due.fault), 32'(i_m_tuser[0]));
                    check_field("dirty_evict", 32'(due.dirty_evict), 32'(i_m_tuser[1]));
                    check_field("frame", 32'(due.frame), 32'(i_m_tdata[4:0]));
                    check_field("fault_total", due.fault_total, i_m_tdata[36:5]);
                    check_field("disk_total", due.disk_total, i_m_tdata[68:37]);
                    check_field("dirty_total", due.dirty_total, i_m_tdata[100:69]);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                awaited_results.push_back(resolve_reference(i_s_tuser[0],
                    {i_s_tdata[1:0], i_s_tdata[8:2]}, i_s_tdata[13:9]));
                references++;
            end
        end
        o_fail_count  <= fail_count;
        o_outstanding <= awaited_results.size();
        o_references  <= references;
        o_faults      <= faults;
        o_evictions   <= evictions;
        o_writebacks  <= writebacks;
    end

endmodule

`default_nettype wire

>>> tb/sv/random_page_replacement_top_tb.sv
// Testbench top for the page replacement block: drives memory references with random
// gaps and output stalls, and gives the verdict from the checker's failure count.
// Depends on rpr_pkg, random_page_replacement_top and rpr_result_checker.
`default_nettype none

module random_page_replacement_top_tb;

    localparam int RANDOM_REFS = 800;
    localparam int POOL_DEPTH  = 80;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                               s_tvalid = 1'b0;
    wire logic                          s_tready;
    logic [rpr_pkg::IN_TDATA_W-1:0]     s_tdata  = '0;
    logic [rpr_pkg::IN_TUSER_W-1:0]     s_tuser  = '0;
    wire logic                          m_tvalid;
    logic                               m_ready  = 1'b0;
    logic                               hold_off = 1'b0;
    wire logic                          m_tready;
    wire logic [rpr_pkg::OUT_TDATA_W-1:0] m_tdata;
    wire logic [rpr_pkg::OUT_TUSER_W-1:0] m_tuser;

    int fail_count;
    int outstanding;
    int references;
    int faults;
    int evictions;
    int writebacks;
    int cycle_count = 0;
    int refs_sent   = 0;
    int results_taken = 0;
    logic send_burst = 1'b1;

    assign m_tready = m_ready && !hold_off;

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    random_page_replacement_top u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    rpr_result_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_references  (references),
        .o_faults      (faults),
        .o_evictions   (evictions),
        .o_writebacks  (writebacks)
    );

    task automatic send_ref(input logic op, input logic [1:0] pid, input logic [6:0] pg,
                            input logic [4:0] victim);
        int gap;
        gap = $urandom_range(0, 14);
        if (send_burst) begin
            gap = 0;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, victim, pg, pid};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        refs_sent++;
    endtask

    // Receiver: a fresh stall before every result, with runs of no stalls.
    initial begin
        int stall;
        logic recv_burst;
        recv_burst = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (results_taken % 64 == 0) begin
                recv_burst = ($urandom_range(0, 3) == 0);
            end
            stall = $urandom_range(0, 14);
            if (recv_burst) begin
                stall = 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_ready <= 1'b1;
            @(posedge clk);
            while (!(m_tvalid && m_tready)) @(posedge clk);
            results_taken++;
        end
    end

    // Long output back-pressure while references keep coming, to fill the block.
    initial begin
        wait (refs_sent >= 300);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("random_page_replacement_top_tb: done, errors");
        $finish;
    end

    initial begin
        logic [8:0] ref_pool[POOL_DEPTH];
        logic [8:0] idx;
        logic [8:0] last_idx;
        logic       op;
        int         pool_size;
        int         pick;
        for (int i = 0; i < POOL_DEPTH; i++) begin
            ref_pool[i] = 9'($urandom_range(0, 511));
        end
        last_idx = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Back-to-back references to one page, then the corners of every field.
        send_ref(rpr_pkg::OP_READ,  2'd0, 7'd0,   5'd0);
        send_ref(rpr_pkg::OP_READ,  2'd0, 7'd0,   5'd31);
        send_ref(rpr_pkg::OP_WRITE, 2'd0, 7'd0,   5'd0);
        send_ref(rpr_pkg::OP_WRITE, 2'd3, 7'd127, 5'd31);
        send_ref(rpr_pkg::OP_READ,  2'd3, 7'd127, 5'd0);
        send_ref(rpr_pkg::OP_WRITE, 2'd3, 7'd127, 5'd21);
        send_ref(rpr_pkg::OP_READ,  2'd0, 7'd127, 5'd10);
        send_ref(rpr_pkg::OP_WRITE, 2'd3, 7'd0,   5'd31);
        send_burst = 1'b0;
        send_ref(rpr_pkg::OP_WRITE, 2'd1, 7'd85,  5'd21);
        send_ref(rpr_pkg::OP_READ,  2'd2, 7'd42,  5'd10);
        send_ref(rpr_pkg::OP_READ,  2'd1, 7'd85,  5'd0);
        send_ref(rpr_pkg::OP_WRITE, 2'd2, 7'd42,  5'd31);
        send_ref(rpr_pkg::OP_READ,  2'd0, 7'd0,   5'd0);
        send_ref(rpr_pkg::OP_READ,  2'd3, 7'd127, 5'd31);
        send_ref(rpr_pkg::OP_WRITE, 2'd1, 7'd127, 5'd15);
        send_ref(rpr_pkg::OP_READ,  2'd2, 7'd0,   5'd16);

        // Mostly a drifting working set that grows from smaller than the frame table to larger,
        // so hits, evictions and dirty writebacks all occur, plus repeats and scattered pages.
        for (int n = 0; n < RANDOM_REFS; n++) begin
            if (n % 64 == 0) begin
                send_burst = ($urandom_range(0, 3) == 0);
            end
            pool_size = (n < 250) ? 24 : (n < 550) ? 40 : POOL_DEPTH;
            if ($urandom_range(0, 49) == 0) begin
                ref_pool[$urandom_range(0, POOL_DEPTH - 1)] = 9'($urandom_range(0, 511));
            end
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                idx = last_idx;
            end else if (pick <= 7) begin
                idx = ref_pool[$urandom_range(0, pool_size - 1)];
            end else begin
                idx = 9'($urandom_range(0, 511));
            end
            op = $urandom_range(0, 1) ? rpr_pkg::OP_WRITE : rpr_pkg::OP_READ;
            send_ref(op, idx[8:7], idx[6:0], 5'($urandom_range(0, 31)));
            last_idx = idx;
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (32) @(posedge clk);

        $display("random_page_replacement_top_tb: %0d references checked, %0d page faults,",
                 references, faults);
        $display("random_page_replacement_top_tb: %0d evictions, %0d of them dirty writebacks",
                 evictions, writebacks);
        if (fail_count == 0) begin
            $display("random_page_replacement_top_tb: done, clean");
        end else begin
            $display("random_page_replacement_top_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
